// ===== src/json_string_unescape_utf8_unit_defines.svh =====
// ---------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Concurrent assertion wrappers shared by the unescaper RTL.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

`ifndef SYNTH

`define JSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON string unescaper package
// Parse modes, result codes, character constants and shared helpers.
// ---------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_BODY   = 7'b0000010,
        MODE_ESC    = 7'b0000100,
        MODE_HEX1   = 7'b0001000,
        MODE_WANTBS = 7'b0010000,
        MODE_WANTU  = 7'b0100000,
        MODE_HEX2   = 7'b1000000
    } mode_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
    localparam logic [2:0] ERR_BSLASH_END   = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;
    localparam logic [2:0] ERR_LOW_MISSING  = 3'd5;
    localparam logic [2:0] ERR_U_MISSING    = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam int         MAX_RESULTS   = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                num;
    } batch_t;

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        if (b inside {[8'h30:8'h39]})
            v = b[3:0];
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
            v = b[3:0] + 4'd9;
        else
            v = 4'd0;
        return v;
    endfunction

    function automatic result_t make_byte(input logic [7:0] d);
        result_t r;
        r.kind = KIND_BYTE;
        r.data = d;
        r.err  = ERR_NONE;
        return r;
    endfunction

    function automatic result_t make_error(input logic [2:0] code);
        result_t r;
        r.kind = KIND_ERROR;
        r.data = 8'h00;
        r.err  = code;
        return r;
    endfunction

endpackage

// ===== src/json_string_unescape_utf8_unit.sv =====
// ---------------------------------------------------------------------------
// JSON string unescaper, UTF-8 output
// Decodes a quoted JSON string literal byte by byte into UTF-8 results.
// ---------------------------------------------------------------------------
// One literal byte is taken per request on the slave side (s_tuser marks end of
// input). Each byte is decoded combinationally into zero to four results, which
// leave the result register on the master side one per cycle while m_tready is
// high. A byte giving no result loads nothing; a byte giving results occupies
// the single output port, and the next byte is taken in the cycle that the last
// of them is handed over.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_defines.svh"

module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic [0:0]  s_tuser,   // end_of_input[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte[7:0], error_code[10:8], zero pad
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    batch_t batch;
    logic   in_accept;
    logic   load;
    logic   free;

    assign s_tready  = free;
    assign in_accept = s_tvalid && s_tready;
    assign load      = in_accept && (batch.num != 3'd0);

    jsu_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .in_byte      (s_tdata),
        .end_of_input (s_tuser[0]),
        .batch        (batch)
    );

    jsu_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch    (batch),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `JSU_ASSERT_NEXT(a_load_shows_result, clk, rst_n, load, m_tvalid, "loaded batch not presented")
    `JSU_ASSERT_IMPLIES(a_ready_only_when_drained, clk, rst_n, s_tready && m_tvalid, m_tlast && m_tready, "request taken over pending results")

endmodule

// ===== src/jsu_parser.sv =====
// ---------------------------------------------------------------------------
// JSON string unescaper parser
// Parse-mode register and single-pass decode of one byte into a result batch.
// ---------------------------------------------------------------------------
module jsu_parser
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output batch_t     batch
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_new;
    logic [20:0] cp;

    function automatic batch_t encode_utf8(input logic [20:0] c);
        batch_t o;
        o = '0;
        if (c <= 21'h7F) begin
            o.res[0] = make_byte(c[7:0]);
            o.num    = 3'd1;
        end
        else if (c <= 21'h7FF) begin
            o.res[0] = make_byte({3'b110, c[10:6]});
            o.res[1] = make_byte({2'b10, c[5:0]});
            o.num    = 3'd2;
        end
        else if (c <= 21'hFFFF) begin
            o.res[0] = make_byte({4'b1110, c[15:12]});
            o.res[1] = make_byte({2'b10, c[11:6]});
            o.res[2] = make_byte({2'b10, c[5:0]});
            o.num    = 3'd3;
        end
        else begin
            o.res[0] = make_byte({5'b11110, c[20:18]});
            o.res[1] = make_byte({2'b10, c[17:12]});
            o.res[2] = make_byte({2'b10, c[11:6]});
            o.res[3] = make_byte({2'b10, c[5:0]});
            o.num    = 3'd4;
        end
        return o;
    endfunction

    assign acc_new = {acc_reg[11:0], hex_value(in_byte)};

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        hs_next   = hs_reg;
        cnt_next  = cnt_reg;
        batch     = '0;
        cp        = '0;
        case (mode_reg)
            MODE_BODY:
            begin
                if (end_of_input) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(ERR_UNTERMINATED);
                    batch.num    = 3'd1;
                end
                else if (in_byte == CH_QUOTE) begin
                    mode_next         = MODE_IDLE;
                    batch.res[0].kind = KIND_DONE;
                    batch.num         = 3'd1;
                end
                else if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end
                else begin
                    batch.res[0] = make_byte(in_byte);
                    batch.num    = 3'd1;
                end
            end
            MODE_ESC:
            begin
                if (end_of_input) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(ERR_BSLASH_END);
                    batch.num    = 3'd1;
                end
                else begin
                    mode_next = MODE_BODY;
                    batch.num = 3'd1;
                    case (in_byte)
                        CH_LC_N: batch.res[0] = make_byte(8'd10);
                        CH_LC_B: batch.res[0] = make_byte(8'd8);
                        CH_LC_F: batch.res[0] = make_byte(8'd12);
                        CH_LC_T: batch.res[0] = make_byte(8'd9);
                        CH_LC_R: batch.res[0] = make_byte(8'd13);
                        CH_SLASH, CH_BSLASH, CH_QUOTE: batch.res[0] = make_byte(in_byte);
                        CH_LC_U:
                        begin
                            mode_next = MODE_HEX1;
                            acc_next  = 16'h0000;
                            cnt_next  = 2'd0;
                            batch.num = 3'd0;
                        end
                        default:
                        begin
                            mode_next    = MODE_IDLE;
                            cnt_next     = 2'd0;
                            batch.res[0] = make_error(ERR_BAD_ESCAPE);
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (end_of_input) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(ERR_UNTERMINATED);
                    batch.num    = 3'd1;
                end
                else begin
                    acc_next = acc_new;
                    if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else begin
                        cnt_next = 2'd0;
                        if (mode_reg == MODE_HEX1 && acc_new[15:10] == HIGH_SURR_TAG) begin
                            hs_next   = acc_new[9:0];
                            mode_next = MODE_WANTBS;
                        end
                        else begin
                            mode_next = MODE_BODY;
                            if (mode_reg == MODE_HEX1)
                                cp = {5'd0, acc_new};
                            else
                                cp = {1'b0, hs_reg, acc_new[9:0]} + 21'h10000;
                            batch = encode_utf8(cp);
                        end
                    end
                end
            end
            MODE_WANTBS:
            begin
                if (end_of_input || in_byte != CH_BSLASH) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(ERR_LOW_MISSING);
                    batch.num    = 3'd1;
                end
                else begin
                    mode_next = MODE_WANTU;
                end
            end
            MODE_WANTU:
            begin
                if (end_of_input || in_byte != CH_LC_U) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(end_of_input ? ERR_LOW_MISSING : ERR_U_MISSING);
                    batch.num    = 3'd1;
                end
                else begin
                    mode_next = MODE_HEX2;
                    acc_next  = 16'h0000;
                    cnt_next  = 2'd0;
                end
            end
            default:
            begin
                if (end_of_input || in_byte != CH_QUOTE) begin
                    mode_next    = MODE_IDLE;
                    cnt_next     = 2'd0;
                    batch.res[0] = make_error(ERR_NO_QUOTE);
                    batch.num    = 3'd1;
                end
                else begin
                    mode_next = MODE_BODY;
                    cnt_next  = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 16'h0000;
            hs_reg   <= 10'h000;
            cnt_reg  <= 2'd0;
        end
        else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            hs_reg   <= hs_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== src/jsu_serializer.sv =====
// ---------------------------------------------------------------------------
// JSON string unescaper result serializer
// Result register holding one batch and issuing its results one per request.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_serializer
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  batch_t      batch,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte[7:0], error_code[10:8], zero pad
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    batch_t     batch_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    result_t    cur;
    logic       out_accept;

    assign cur        = batch_reg.res[idx_reg];
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {5'd0, cur.err, cur.data};
    assign m_tuser    = cur.kind;
    assign m_tlast    = ({1'b0, idx_reg} + 3'd1) == batch_reg.num;
    assign out_accept = valid_reg && m_tready;
    assign free       = !valid_reg || (out_accept && m_tlast);

    // hold the batch payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            batch_reg <= batch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (out_accept) begin
            if (m_tlast)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    `JSU_ASSERT_NEXT(a_no_drop_mid_batch, clk, rst_n, out_accept && !m_tlast, m_tvalid, "batch dropped before its last result")
    `JSU_ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, valid_reg, {1'b0, idx_reg} < batch_reg.num, "result index beyond batch size")

endmodule
